### rtl/min_tracking_stack_defines.svh
// Assertion macros for the RTL of the min tracking stack.
`ifndef MIN_TRACKING_STACK_DEFINES_SVH
`define MIN_TRACKING_STACK_DEFINES_SVH

// Checks that a condition holds at every clock edge outside reset.
`define MTS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define MTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/mts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mts_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int TOTAL_W     = 8;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } command_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_RELOAD
    } state_t;

    typedef struct packed {
        command_t                  command;
        logic signed [DATA_W-1:0]  value;
    } req_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  popped_value;
        logic signed [DATA_W-1:0]  min_value;
        logic                      is_empty;
        status_t                   status;
        logic [TOTAL_W-1:0]        entry_total;
    } rsp_word_t;

endpackage

`default_nettype wire

### rtl/mts_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mts_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 128,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/min_tracking_stack.sv
`timescale 1ns / 1ps
`default_nettype none

// Bounded stack of signed 32-bit words that also reports the smallest value held. The top of
// the value stack and the top of the minimum stack are kept in registers, and the full stacks
// live in two single-port-read memories. A push, an overflow push and an underflow pop each
// complete in the idle state, so pushes stream at one word per cycle unless a result is held
// by a stall, which holds off the input. A pop that removes an entry also passes through a
// reload state, as the new tops come back from the memories in the cycle after the read is
// issued. The result word sits in an output register; the next word is taken as it leaves.

`include "min_tracking_stack_defines.svh"

module min_tracking_stack (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire mts_pkg::req_word_t req,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output mts_pkg::rsp_word_t      rsp
);

    mts_pkg::state_t state_reg, state_next;

    logic [mts_pkg::CNT_W-1:0]          vcount_reg, vcount_next;
    logic [mts_pkg::CNT_W-1:0]          mcount_reg, mcount_next;
    logic signed [mts_pkg::DATA_W-1:0]  val_top_reg, val_top_next;
    logic signed [mts_pkg::DATA_W-1:0]  min_top_reg, min_top_next;
    logic signed [mts_pkg::DATA_W-1:0]  pend_popped_reg, pend_popped_next;
    logic                               pend_minpop_reg, pend_minpop_next;
    logic                               rsp_valid_reg, rsp_valid_next;
    mts_pkg::rsp_word_t                 rsp_reg, rsp_next;

    logic                               accept;
    logic                               vmem_we, mmem_we, mem_re;
    logic [mts_pkg::ADDR_W-1:0]         vmem_waddr, mmem_waddr, vmem_raddr, mmem_raddr;
    logic [mts_pkg::DATA_W-1:0]         vmem_rdata, mmem_rdata;
    logic                               min_push;
    logic                               min_pop;

    assign req_stall = (state_reg != mts_pkg::S_IDLE) || (rsp_valid_reg && rsp_stall);
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign vmem_waddr = mts_pkg::ADDR_W'(vcount_reg);
    assign mmem_waddr = mts_pkg::ADDR_W'(mcount_reg);
    assign vmem_raddr = mts_pkg::ADDR_W'(vcount_reg - mts_pkg::CNT_W'(2));
    assign mmem_raddr = mts_pkg::ADDR_W'(mcount_reg - mts_pkg::CNT_W'(2));

    assign min_push = (mcount_reg == '0) ||
                      ((mcount_reg < mts_pkg::CNT_W'(mts_pkg::STACK_DEPTH)) &&
                       (req.value <= min_top_reg));
    assign min_pop  = (mcount_reg != '0) && (min_top_reg == val_top_reg);

    mts_ram #(
        .WIDTH (mts_pkg::DATA_W),
        .DEPTH (mts_pkg::STACK_DEPTH)
    ) u_value_ram (
        .clk   (clk),
        .we    (vmem_we),
        .waddr (vmem_waddr),
        .wdata (req.value),
        .re    (mem_re),
        .raddr (vmem_raddr),
        .rdata (vmem_rdata)
    );

    mts_ram #(
        .WIDTH (mts_pkg::DATA_W),
        .DEPTH (mts_pkg::STACK_DEPTH)
    ) u_minimum_ram (
        .clk   (clk),
        .we    (mmem_we),
        .waddr (mmem_waddr),
        .wdata (req.value),
        .re    (mem_re),
        .raddr (mmem_raddr),
        .rdata (mmem_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mts_pkg::S_IDLE:
            begin
                if (accept && (req.command == mts_pkg::CMD_POP) && (vcount_reg != '0))
                begin
                    state_next = mts_pkg::S_RELOAD;
                end
            end
            mts_pkg::S_RELOAD:
            begin
                state_next = mts_pkg::S_IDLE;
            end
            default:
            begin
                state_next = mts_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        vcount_next      = vcount_reg;
        mcount_next      = mcount_reg;
        val_top_next     = val_top_reg;
        min_top_next     = min_top_reg;
        pend_popped_next = pend_popped_reg;
        pend_minpop_next = pend_minpop_reg;
        rsp_valid_next   = rsp_valid_reg && rsp_stall;
        rsp_next         = rsp_reg;
        vmem_we          = 1'b0;
        mmem_we          = 1'b0;
        mem_re           = 1'b0;
        case (state_reg)
            mts_pkg::S_IDLE:
            begin
                if (accept && (req.command == mts_pkg::CMD_PUSH))
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.popped_value = '0;
                    if (vcount_reg == mts_pkg::CNT_W'(mts_pkg::STACK_DEPTH))
                    begin
                        rsp_next.status = mts_pkg::STAT_OVERFLOW;
                    end
                    else
                    begin
                        rsp_next.status = mts_pkg::STAT_OK;
                        vmem_we         = 1'b1;
                        vcount_next     = vcount_reg + mts_pkg::CNT_W'(1);
                        val_top_next    = req.value;
                        if (min_push)
                        begin
                            mmem_we      = 1'b1;
                            mcount_next  = mcount_reg + mts_pkg::CNT_W'(1);
                            min_top_next = req.value;
                        end
                    end
                    rsp_next.min_value   = min_top_next;
                    rsp_next.is_empty    = 1'b0;
                    rsp_next.entry_total = mts_pkg::TOTAL_W'(vcount_next);
                end
                else if (accept && (vcount_reg == '0))
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.popped_value = '0;
                    rsp_next.min_value    = '0;
                    rsp_next.is_empty     = 1'b1;
                    rsp_next.status       = mts_pkg::STAT_UNDERFLOW;
                    rsp_next.entry_total  = '0;
                end
                else if (accept)
                begin
                    mem_re           = 1'b1;
                    pend_popped_next = val_top_reg;
                    pend_minpop_next = min_pop;
                    vcount_next      = vcount_reg - mts_pkg::CNT_W'(1);
                    if (min_pop)
                    begin
                        mcount_next = mcount_reg - mts_pkg::CNT_W'(1);
                    end
                end
            end
            mts_pkg::S_RELOAD:
            begin
                val_top_next = vmem_rdata;
                if (pend_minpop_reg)
                begin
                    min_top_next = mmem_rdata;
                end
                rsp_valid_next        = 1'b1;
                rsp_next.popped_value = pend_popped_reg;
                rsp_next.min_value    = ((vcount_reg == '0) || (mcount_reg == '0)) ?
                                        '0 : min_top_next;
                rsp_next.is_empty     = (vcount_reg == '0);
                rsp_next.status       = mts_pkg::STAT_OK;
                rsp_next.entry_total  = mts_pkg::TOTAL_W'(vcount_reg);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mts_pkg::S_IDLE;
            vcount_reg    <= '0;
            mcount_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            vcount_reg    <= vcount_next;
            mcount_reg    <= mcount_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_top_reg     <= val_top_next;
        min_top_reg     <= min_top_next;
        pend_popped_reg <= pend_popped_next;
        pend_minpop_reg <= pend_minpop_next;
        rsp_reg         <= rsp_next;
    end

    `MTS_ASSERT_ALWAYS(a_min_count_bounded, mcount_reg <= vcount_reg,
        "minimum stack holds more entries than the value stack")

    `MTS_ASSERT_ALWAYS(a_min_nonempty, (vcount_reg == '0) || (mcount_reg != '0),
        "value stack holds entries while the minimum stack is empty")

    `MTS_ASSERT_ALWAYS(a_count_bounded,
        vcount_reg <= mts_pkg::CNT_W'(mts_pkg::STACK_DEPTH),
        "entry count exceeds the stack depth")

    `MTS_ASSERT_NEXT(a_pop_reload,
        accept && (req.command == mts_pkg::CMD_POP) && (vcount_reg != '0),
        (state_reg == mts_pkg::S_RELOAD) && !rsp_valid_reg,
        "pop of a nonempty stack did not enter the reload cycle")

endmodule

`default_nettype wire
